// ----- rtl/can_arb_pkg.sv -----
// shared types, widths and op codes for the can arbitration table
package can_arb_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned NodeCountDef  = 16;

  localparam int unsigned OpW   = 3;
  localparam int unsigned IdW   = 29;
  localparam int unsigned NodeW = 4;
  localparam int unsigned TimeW = 32;

  // winner identifier after reset or after an empty arbitration
  localparam logic [IdW-1:0] IdMax = '1;

  typedef enum logic [OpW-1:0] {
    OP_REGISTER   = 3'd0,
    OP_CHECKOUT   = 3'd1,
    OP_ARBITRATE  = 3'd2,
    OP_TX_DONE    = 3'd3,
    OP_ERROR      = 3'd4,
    OP_ERROR_DONE = 3'd5
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [IdW-1:0]   can_id;
    logic [NodeW-1:0] node;
    logic [TimeW-1:0] sign_in_time;
    logic             remote_request;
  } in_item_t;

  typedef struct packed {
    logic             granted;
    logic [IdW-1:0]   grant_id;
    logic [NodeW-1:0] grant_node;
    logic [TimeW-1:0] grant_sign_in_time;
    logic             duplicate_sender;
    logic             table_full;
    logic             arbitration_start;
    logic             error_forwarded;
    logic             done_valid;
    logic [IdW-1:0]   done_id;
    logic [NodeW-1:0] done_node;
    logic             bus_idle;
  } out_item_t;

  // one table entry as kept in the slot memory
  typedef struct packed {
    logic             remote;
    logic [TimeW-1:0] sign_in_time;
    logic [IdW-1:0]   id;
    logic [NodeW-1:0] node;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

endpackage

// ----- rtl/can_arb_req_if.sv -----
// request channel: valid/ready handshake carrying one bus event word
interface can_arb_req_if;
  import can_arb_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/can_arb_rsp_if.sv -----
// response channel: valid/ready handshake carrying one result word
interface can_arb_rsp_if;
  import can_arb_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/can_arb_ram.sv -----
// generic single write port, single read port ram with registered read
module can_arb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/can_bus_arbitration_table_unit.sv -----
// top level: can frame registration table with lowest-identifier arbitration
//
// the block holds up to TABLE_DEPTH pending frame registrations, packed in
// registration order in one slot memory, with a mark bit per slot in flops.
// each request word carries a bus event (register, checkout, arbitrate,
// transmission done, error frame, error done) and yields exactly one
// response word. one request is worked on at a time; a finished response
// waits in an output register while the next request is taken. register,
// error frame and unused ops finish without a sweep of the table. checkout
// sweeps the filled slots and compacts them to drop the first entry with a
// matching identifier; arbitrate and error done sweep them to find the
// lowest identifier; transmission done first sweeps out the marked entries,
// compacting the rest, and then runs an arbitration sweep on what remains.
// ready comes back on the edge that raises the response valid. the sweeps
// are limited by the memory's single read port and the one shared
// identifier comparator, which together handle one slot per cycle. there is
// no clearing pass after reset: slots above the fill count are never read.
module can_bus_arbitration_table_unit #(
  parameter int unsigned TABLE_DEPTH = can_arb_pkg::TableDepthDef,
  parameter int unsigned NODE_COUNT  = can_arb_pkg::NodeCountDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  can_arb_req_if.sink   req_i,
  can_arb_rsp_if.source rsp_o
);
  import can_arb_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_OUT
  } state_e;

  // what the current slot sweep does
  typedef enum logic [1:0] {
    SW_CHECKOUT,
    SW_DROP_MARKED,
    SW_ARB
  } sweep_e;

  state_e            state_q;
  sweep_e            kind_q;
  in_item_t          item_q;
  out_item_t         res_q;
  out_item_t         rsp_q;
  logic              rsp_valid_q;

  // table bookkeeping
  logic [CntW-1:0]        count_q;
  logic [TABLE_DEPTH-1:0] marked_q;
  logic [IdW-1:0]         winner_id_q;
  logic [NodeW-1:0]       winner_node_q;
  logic                   idle_q;
  logic                   err_q;

  // sweep pointers
  logic [CntW-1:0]   rd_ptr_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [CntW-1:0]   wr_ptr_q;
  logic              hit_q;

  // running arbitration result
  logic              found_q;
  logic [IdW-1:0]    best_id_q;
  logic [NodeW-1:0]  first_node_q;
  logic [TimeW-1:0]  first_time_q;
  logic [NodeW-1:0]  data_node_q;
  logic [TimeW-1:0]  data_time_q;
  logic [1:0]        senders_q;

  // memory port and shared compare unit
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [SlotW-1:0]  ram_wdata;
  logic              ram_re;
  logic [IdxW-1:0]   ram_raddr;
  logic [SlotW-1:0]  ram_rdata;
  slot_t             entry;
  slot_t             new_slot;
  logic [IdW-1:0]    cmp_id;
  logic              id_lt;
  logic              id_eq;
  logic              drop;
  logic              keep_wr;
  logic              node_ok;
  logic              do_register;
  logic              sweep_end;
  logic              req_fire;
  logic              rsp_fire;

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;

  // out-of-range nodes are ignored on registration
  assign node_ok     = 32'(item_q.node) < NODE_COUNT;
  assign do_register = (state_q == ST_EXEC) && (op_e'(item_q.op) == OP_REGISTER)
                       && node_ok && (count_q != CntFull);

  always_comb begin
    entry                 = slot_t'(ram_rdata);
    new_slot.remote       = item_q.remote_request;
    new_slot.sign_in_time = item_q.sign_in_time;
    new_slot.id           = item_q.can_id;
    new_slot.node         = item_q.node;

    // one identifier comparator, shared by checkout search and arbitration
    cmp_id = (kind_q == SW_CHECKOUT) ? item_q.can_id : best_id_q;
    id_lt  = entry.id < cmp_id;
    id_eq  = entry.id == cmp_id;

    case (kind_q)
      SW_CHECKOUT:    drop = !hit_q && id_eq;
      SW_DROP_MARKED: drop = marked_q[rd_idx_q];
      default:        drop = 1'b0;
    endcase

    keep_wr = (state_q == ST_SWEEP) && rd_vld_q && (kind_q != SW_ARB) && !drop;

    ram_re    = (state_q == ST_SWEEP) && (rd_ptr_q < count_q);
    ram_raddr = rd_ptr_q[IdxW-1:0];

    if (do_register) begin
      ram_we    = 1'b1;
      ram_waddr = count_q[IdxW-1:0];
      ram_wdata = new_slot;
    end else begin
      // compaction: move a kept entry down only when a hole opened below it
      ram_we    = keep_wr && (wr_ptr_q != CntW'(rd_idx_q));
      ram_waddr = wr_ptr_q[IdxW-1:0];
      ram_wdata = ram_rdata;
    end

    sweep_end = (state_q == ST_SWEEP) && !ram_re && !rd_vld_q;
  end

  can_arb_ram #(
    .Width (SlotW),
    .Depth (TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      kind_q        <= SW_ARB;
      item_q        <= '0;
      res_q         <= '0;
      rsp_q         <= '0;
      rsp_valid_q   <= 1'b0;
      count_q       <= '0;
      marked_q      <= '0;
      winner_id_q   <= IdMax;
      winner_node_q <= '0;
      idle_q        <= 1'b1;
      err_q         <= 1'b0;
      rd_ptr_q      <= '0;
      rd_vld_q      <= 1'b0;
      rd_idx_q      <= '0;
      wr_ptr_q      <= '0;
      hit_q         <= 1'b0;
      found_q       <= 1'b0;
      best_id_q     <= '0;
      first_node_q  <= '0;
      first_time_q  <= '0;
      data_node_q   <= '0;
      data_time_q   <= '0;
      senders_q     <= '0;
    end else begin
      // a new word loaded in ST_OUT keeps the output valid
      if (rsp_fire && (state_q != ST_OUT)) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            item_q  <= req_i.data;
            res_q   <= '0;
            state_q <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          // clear the sweep pointers and running result for a sweep that may follow
          rd_ptr_q <= '0;
          rd_vld_q <= 1'b0;
          wr_ptr_q <= '0;
          hit_q    <= 1'b0;
          found_q  <= 1'b0;
          senders_q <= '0;
          case (op_e'(item_q.op))
            OP_REGISTER: begin
              if (node_ok) begin
                if (count_q == CntFull) begin
                  res_q.table_full <= 1'b1;
                end else begin
                  count_q                        <= count_q + CntW'(1);
                  marked_q[count_q[IdxW-1:0]]    <= 1'b0;
                  if (idle_q) begin
                    idle_q                  <= 1'b0;
                    res_q.arbitration_start <= 1'b1;
                  end
                end
              end
              state_q <= ST_OUT;
            end
            OP_CHECKOUT: begin
              kind_q  <= SW_CHECKOUT;
              state_q <= ST_SWEEP;
            end
            OP_ARBITRATE: begin
              kind_q   <= SW_ARB;
              marked_q <= '0;
              state_q  <= ST_SWEEP;
            end
            OP_TX_DONE: begin
              err_q   <= 1'b0;
              kind_q  <= SW_DROP_MARKED;
              state_q <= ST_SWEEP;
            end
            OP_ERROR: begin
              if (!err_q) begin
                err_q                 <= 1'b1;
                res_q.error_forwarded <= 1'b1;
              end
              state_q <= ST_OUT;
            end
            OP_ERROR_DONE: begin
              err_q    <= 1'b0;
              kind_q   <= SW_ARB;
              marked_q <= '0;
              state_q  <= ST_SWEEP;
            end
            default: begin
              state_q <= ST_OUT;
            end
          endcase
        end

        ST_SWEEP: begin
          // issue one slot read per cycle
          rd_vld_q <= ram_re;
          rd_idx_q <= rd_ptr_q[IdxW-1:0];
          if (ram_re) begin
            rd_ptr_q <= rd_ptr_q + CntW'(1);
          end

          // handle the slot whose data just came back
          if (rd_vld_q) begin
            if (kind_q == SW_ARB) begin
              if (!found_q || id_lt) begin
                // new lowest identifier: restart marks and sender tally
                found_q      <= 1'b1;
                best_id_q    <= entry.id;
                first_node_q <= entry.node;
                first_time_q <= entry.sign_in_time;
                marked_q     <= TABLE_DEPTH'(1) << rd_idx_q;
                if (!entry.remote) begin
                  senders_q   <= 2'd1;
                  data_node_q <= entry.node;
                  data_time_q <= entry.sign_in_time;
                end else begin
                  senders_q <= 2'd0;
                end
              end else if (id_eq) begin
                marked_q[rd_idx_q] <= 1'b1;
                if (!entry.remote) begin
                  senders_q   <= (senders_q == 2'd0) ? 2'd1 : 2'd2;
                  data_node_q <= entry.node;
                  data_time_q <= entry.sign_in_time;
                end
              end
            end else if (drop) begin
              hit_q <= 1'b1;
            end else begin
              marked_q[wr_ptr_q[IdxW-1:0]] <= marked_q[rd_idx_q];
              wr_ptr_q                     <= wr_ptr_q + CntW'(1);
            end
          end

          if (sweep_end) begin
            case (kind_q)
              SW_CHECKOUT: begin
                count_q <= wr_ptr_q;
                state_q <= ST_OUT;
              end
              SW_DROP_MARKED: begin
                count_q <= wr_ptr_q;
                if (hit_q) begin
                  res_q.done_valid <= 1'b1;
                  res_q.done_id    <= winner_id_q;
                  res_q.done_node  <= winner_node_q;
                end
                // chain straight into a fresh arbitration
                kind_q    <= SW_ARB;
                marked_q  <= '0;
                rd_ptr_q  <= '0;
                wr_ptr_q  <= '0;
                hit_q     <= 1'b0;
                found_q   <= 1'b0;
                senders_q <= '0;
              end
              default: begin
                if (found_q) begin
                  winner_id_q              <= best_id_q;
                  res_q.granted            <= 1'b1;
                  res_q.grant_id           <= best_id_q;
                  res_q.duplicate_sender   <= (senders_q == 2'd2);
                  if (senders_q != 2'd0) begin
                    winner_node_q            <= data_node_q;
                    res_q.grant_node         <= data_node_q;
                    res_q.grant_sign_in_time <= data_time_q;
                  end else begin
                    winner_node_q            <= first_node_q;
                    res_q.grant_node         <= first_node_q;
                    res_q.grant_sign_in_time <= first_time_q;
                  end
                end else begin
                  // empty table: bus goes idle
                  winner_id_q   <= IdMax;
                  winner_node_q <= '0;
                  idle_q        <= 1'b1;
                end
                state_q <= ST_OUT;
              end
            endcase
          end
        end

        ST_OUT: begin
          // hand the word over once the output register is free
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_q       <= {res_q[$bits(out_item_t)-1:1], idle_q};
            rsp_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("fill count beyond table depth");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q |-> (count_q == '0))
    else $error("bus idle while entries are pending");

  a_read_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CntW'(rd_idx_q) < count_q))
    else $error("sweep read beyond fill count");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && rd_vld_q && kind_q != SW_ARB)
      |-> (wr_ptr_q <= CntW'(rd_idx_q)))
    else $error("compaction write ahead of read");

  a_dup_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (!rsp_o.data.duplicate_sender || rsp_o.data.granted))
    else $error("duplicate sender without grant");
`endif

endmodule
